// ===== hdl/serial_id_handshake_macros.svh =====
// Assertion macros for the serial ID handshake checker.
// No dependencies; included by the checker file only.
`ifndef SERIAL_ID_HANDSHAKE_MACROS_SVH
`define SERIAL_ID_HANDSHAKE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SIH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define SIH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sih_pkg.sv =====
// Shared types and constants for the serial ID handshake.
// No dependencies; used by the top level and the checker.
package sih_pkg;

	localparam int MAGIC_LEN = 4;
	localparam int CNT_W     = $clog2(MAGIC_LEN + 1);

	typedef logic [15:0]      half_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam half_t MAGIC_WORDS [4] = '{16'h494e, 16'h544e, 16'h4e45, 16'h4f44};

	localparam logic CFG_LINK_MODE = 1'b0;
	localparam logic CFG_OWN_ID    = 1'b1;

	localparam logic  LINK_MODE_RESET = 1'b1;
	localparam half_t OWN_ID_RESET    = 16'h8001;

endpackage

// ===== hdl/serial_id_handshake.sv =====
// Serial ID handshake, top level: input register, match/capture step, result register.
// Depends on sih_pkg.
//
// One received word is accepted per cycle while the result side does not stall, and its
// result reaches the output through the input register, then the result register.
// The rate is set by the update of the match count, echo and ID registers, which sits
// between the input register and the result register. A stalled result register holds the
// input register, which then stalls the input side. Configuration (link_mode, own_id)
// is written through the cfg port, always ready.
module serial_id_handshake (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         rx_word,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         tx_word,
	output logic                id_valid,
	output logic [15:0]         partner_id,
	output logic                restart_transfer,
	output logic [2:0]          progress,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);

	logic                link_mode_q;
	sih_pkg::half_t      own_id_q;

	logic                rx_valid_s1;
	logic [31:0]         rx_word_s1;

	sih_pkg::cnt_t       match_count_q;
	sih_pkg::half_t      sent_word_q;
	sih_pkg::half_t      expected_echo_q;
	sih_pkg::half_t      found_id_q;

	logic                out_valid_q;
	logic [31:0]         tx_word_q;
	logic                id_valid_q;
	sih_pkg::half_t      partner_id_q;
	logic                restart_q;
	logic [2:0]          progress_q;

	logic                advance;
	sih_pkg::half_t      echo;
	sih_pkg::half_t      data;
	sih_pkg::cnt_t       cnt_n;
	sih_pkg::half_t      found_n;
	sih_pkg::half_t      sent_n;
	sih_pkg::half_t      exp_n;
	logic [31:0]         tx_n;
	logic                restart_n;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = rx_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_mode_q <= sih_pkg::LINK_MODE_RESET;
			own_id_q    <= sih_pkg::OWN_ID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sih_pkg::CFG_LINK_MODE: link_mode_q <= cfg_data[0];
				sih_pkg::CFG_OWN_ID:    own_id_q    <= cfg_data;
				default:                ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			rx_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rx_word_s1 <= rx_word;
		end
	end

	// master: echo in the low half; slave: halves swapped
	always_comb begin
		echo    = link_mode_q ? rx_word_s1[15:0]  : rx_word_s1[31:16];
		data    = link_mode_q ? rx_word_s1[31:16] : rx_word_s1[15:0];
		cnt_n   = match_count_q;
		found_n = found_id_q;
		if (found_id_q == '0) begin
			if (echo == expected_echo_q) begin
				if (match_count_q < sih_pkg::CNT_W'(sih_pkg::MAGIC_LEN)) begin
					if (expected_echo_q == ~sent_word_q && data == ~expected_echo_q) begin
						cnt_n = match_count_q + 1'b1;
					end
				end else begin
					found_n = data;
				end
			end else begin
				cnt_n = '0;
			end
		end
		if (cnt_n < sih_pkg::CNT_W'(sih_pkg::MAGIC_LEN)) begin
			sent_n = sih_pkg::MAGIC_WORDS[2'(cnt_n)];
		end else begin
			sent_n = own_id_q;
		end
		exp_n     = ~data;
		tx_n      = link_mode_q ? {exp_n, sent_n} : {sent_n, exp_n};
		restart_n = link_mode_q && (found_n == '0) &&
			((cnt_n != '0) || (data == sih_pkg::MAGIC_WORDS[0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			match_count_q   <= '0;
			sent_word_q     <= '0;
			expected_echo_q <= '0;
			found_id_q      <= '0;
		end else if (advance) begin
			out_valid_q <= rx_valid_s1;
			if (rx_valid_s1) begin
				match_count_q   <= cnt_n;
				sent_word_q     <= sent_n;
				expected_echo_q <= exp_n;
				found_id_q      <= found_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && rx_valid_s1) begin
			tx_word_q    <= tx_n;
			id_valid_q   <= (found_n != '0);
			partner_id_q <= found_n;
			restart_q    <= restart_n;
			progress_q   <= 3'(cnt_n);
		end
	end

	assign out_valid        = out_valid_q;
	assign tx_word          = tx_word_q;
	assign id_valid         = id_valid_q;
	assign partner_id       = partner_id_q;
	assign restart_transfer = restart_q;
	assign progress         = progress_q;

endmodule

// ===== hdl/sih_checker.sv =====
// Port-level checks for the serial ID handshake, bound to the top level.
// Depends on sih_pkg and serial_id_handshake_macros.svh.
`include "serial_id_handshake_macros.svh"

module sih_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [31:0] rx_word,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] tx_word,
	input logic        id_valid,
	input logic [15:0] partner_id,
	input logic        restart_transfer,
	input logic [2:0]  progress,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        cfg_index,
	input logic [15:0] cfg_data
);

	// a held result keeps its word
	`SIH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(tx_word), "result changed while stalled")

	`SIH_ASSERT_NOW(a_id_flag, clk, arst_n, out_valid, id_valid == (partner_id != 16'h0), "id_valid disagrees with partner_id")

	`SIH_ASSERT_NOW(a_restart_no_id, clk, arst_n, out_valid && restart_transfer, !id_valid, "restart requested with ID held")

	`SIH_ASSERT_NOW(a_progress_max, clk, arst_n, out_valid, progress <= 3'(sih_pkg::MAGIC_LEN), "progress beyond sequence length")

	// input side backs up only behind a stalled result
	`SIH_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled with result side free")

endmodule

bind serial_id_handshake sih_checker u_sih_checker (.*);
